// File: rtl/csds_pkg.sv
// ----------------------------------------------------------------------------
// csds_pkg
// Shared types and constants of the clock sync supervisor.
// ----------------------------------------------------------------------------
package csds_pkg;

  localparam logic [7:0] UPDATE_TICKS   = 8'd10;
  localparam logic [7:0] FAILS_TO_RESET = 8'd5;
  localparam logic [7:0] RESET_DELAY    = 8'd100;
  localparam logic [2:0] SUNDAY_CODE    = 3'd7;

  localparam logic [11:0] MINUTES_PER_DAY = 12'd1440;
  localparam logic [10:0] LAST_MINUTE     = 11'(23 * 60 + 59);
  localparam logic [5:0]  MARCH_OCT_DAYS  = 6'd31;
  localparam logic [10:0] MINUTES_PER_HR  = 11'd60;

  localparam logic [3:0] MONTH_MARCH   = 4'd3;
  localparam logic [3:0] MONTH_OCTOBER = 4'd10;

  // command codes
  localparam logic [1:0] CMD_TICK    = 2'd0;
  localparam logic [1:0] CMD_PROCESS = 2'd1;
  localparam logic [1:0] CMD_SET     = 2'd2;

  // configuration register indexes
  localparam logic [1:0] REG_AUTO_TRANSITION = 2'd0;
  localparam logic [1:0] REG_SYNC_START      = 2'd1;
  localparam logic [1:0] REG_SYNC_LENGTH     = 2'd2;

  // pending daylight-saving change
  localparam logic [1:0] CHG_NONE   = 2'd0;
  localparam logic [1:0] CHG_SUMMER = 2'd1;
  localparam logic [1:0] CHG_WINTER = 2'd2;

  typedef struct packed {
    logic [1:0] cmd;
    logic [6:0] year;
    logic [3:0] month;
    logic [4:0] day;
    logic [4:0] hours;
    logic [5:0] minutes;
    logic [2:0] weekday;
    logic       frame_ok;
    logic [7:0] fail_count;
  } item_t;

  typedef struct packed {
    logic       receiver_start;
    logic       receiver_stop;
    logic       write_decoded;
    logic       write_current;
    logic [4:0] held_hours;
    logic [1:0] transition;
    logic       synced_today;
  } result_t;

  typedef struct packed {
    logic        auto_transition;
    logic [10:0] sync_start_minutes;
    logic [10:0] sync_length_minutes;
  } cfg_t;

  typedef struct packed {
    logic [7:0]  refresh_count;
    logic [7:0]  restart_delay;
    logic        receiver_on;
    logic        sync_done;
    logic        new_day;
    logic [1:0]  pending_change;
    logic [10:0] last_minute_of_day;
    logic [15:0] held_date;   // year, month, day from the top bits down
    logic [10:0] held_time;   // hours, minutes
    logic [2:0]  held_weekday;
  } sup_state_t;

endpackage

// File: rtl/clock_sync_dst_supervisor_core.sv
// ----------------------------------------------------------------------------
// clock_sync_dst_supervisor_core
// RTC supervisor with radio sync window and daylight-saving hour change.
//
//   channel  | dir | handshake             | payload
//   ---------+-----+-----------------------+---------------------------------
//   s_axis   | in  | s_tvalid / s_tready   | s_tuser cmd, s_tdata time+radio
//   m_axis   | out | m_tvalid / m_tready   | m_tdata command flags + status
//   cfg      | in  | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// One item per cycle unless the m side stalls; items pass the input register, then the result register.
// The step is a single combinational pass between the two registers; state
// updates when the result register loads. A stalled m side holds the result;
// the input register takes a beat only while empty or while the result drains.
// Reset: synchronous, clears state to defaults; cfg is always ready.
// ----------------------------------------------------------------------------
module clock_sync_dst_supervisor_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // year[6:0] month[10:7] day[15:11] hours[20:16] minutes[26:21]
  // weekday[29:27] frame_ok[30] fail_count[38:31], zero [39]
  input  logic [39:0] s_tdata,
  // cmd[1:0]
  input  logic [1:0]  s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // receiver_start[0] receiver_stop[1] write_decoded[2] write_current[3]
  // held_hours[8:4] transition[10:9] synced_today[11], zero [15:12]
  output logic [15:0] m_tdata,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [10:0] cfg_data
);
  import csds_pkg::*;

  cfg_t       cfg;
  item_t      in_item;
  logic       in_full;
  sup_state_t st;
  sup_state_t st_next;
  result_t    res;
  result_t    out_res;
  logic       fire;

  assign cfg_ready = 1'b1;

  csds_cfg u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  assign fire     = in_full && (!m_tvalid || m_tready);
  assign s_tready = !in_full || fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (s_tready) begin
      in_full <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_item.cmd        <= s_tuser;
      in_item.year       <= s_tdata[6:0];
      in_item.month      <= s_tdata[10:7];
      in_item.day        <= s_tdata[15:11];
      in_item.hours      <= s_tdata[20:16];
      in_item.minutes    <= s_tdata[26:21];
      in_item.weekday    <= s_tdata[29:27];
      in_item.frame_ok   <= s_tdata[30];
      in_item.fail_count <= s_tdata[38:31];
    end
  end

  csds_step u_step (
    .item    (in_item),
    .cfg     (cfg),
    .st      (st),
    .st_next (st_next),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      st.refresh_count      <= UPDATE_TICKS;
      st.restart_delay      <= 8'd0;
      st.receiver_on        <= 1'b0;
      st.sync_done          <= 1'b0;
      st.new_day            <= 1'b1;
      st.pending_change     <= CHG_NONE;
      st.last_minute_of_day <= 11'd0;
      st.held_date          <= 16'd0;
      st.held_time          <= 11'd0;
      st.held_weekday       <= 3'd0;
    end else if (fire) begin
      st <= st_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (fire) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) out_res <= res;
  end

  assign m_tdata = {4'd0, out_res.synced_today, out_res.transition, out_res.held_hours,
                    out_res.write_current, out_res.write_decoded,
                    out_res.receiver_stop, out_res.receiver_start};

endmodule

// File: rtl/csds_cfg.sv
// ----------------------------------------------------------------------------
// csds_cfg
// Configuration register file: window position and auto change enable.
// ----------------------------------------------------------------------------
module csds_cfg (
  input  logic                clk,
  input  logic                rst,
  input  logic                wr_en,
  input  logic [1:0]          wr_index,
  input  logic [10:0]         wr_data,
  output csds_pkg::cfg_t      cfg
);
  import csds_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.auto_transition     <= 1'b0;
      cfg.sync_start_minutes  <= 11'd0;
      cfg.sync_length_minutes <= 11'd60;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_AUTO_TRANSITION: cfg.auto_transition     <= wr_data[0];
        REG_SYNC_START:      cfg.sync_start_minutes  <= wr_data;
        REG_SYNC_LENGTH:     cfg.sync_length_minutes <= wr_data;
        default: ;  // unmapped index, ignored
      endcase
    end
  end

endmodule

// File: rtl/csds_step.sv
// ----------------------------------------------------------------------------
// csds_step
// One supervisor step: item plus current state gives next state and result.
// ----------------------------------------------------------------------------
module csds_step (
  input  csds_pkg::item_t      item,
  input  csds_pkg::cfg_t       cfg,
  input  csds_pkg::sup_state_t st,
  output csds_pkg::sup_state_t st_next,
  output csds_pkg::result_t    res
);
  import csds_pkg::*;

  always_comb begin
    sup_state_t  s;
    logic        start;
    logic        stop;
    logic        wdec;
    logic        wcur;
    logic [15:0] load_date;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hours;
    logic [5:0]  minutes;
    logic [10:0] cur;
    logic [11:0] hi;
    logic [11:0] hi_wrap;
    logic        can;

    s         = st;
    start     = 1'b0;
    stop      = 1'b0;
    wdec      = 1'b0;
    wcur      = 1'b0;
    load_date = {item.year, item.month, item.day};
    month     = 4'd0;
    day       = 5'd0;
    hours     = 5'd0;
    minutes   = 6'd0;
    cur       = 11'd0;
    hi        = 12'd0;
    hi_wrap   = 12'd0;
    can       = 1'b0;

    case (item.cmd)
      CMD_TICK: begin
        s.refresh_count = st.refresh_count + 8'd1;
        if (st.restart_delay != 8'd0) begin
          s.restart_delay = st.restart_delay - 8'd1;
          if (st.restart_delay == 8'd1 && !st.receiver_on) begin
            s.receiver_on = 1'b1;
            start         = 1'b1;
          end
        end
      end

      CMD_PROCESS: begin
        if (item.frame_ok) begin
          stop          = 1'b1;
          s.receiver_on = 1'b0;
          wdec          = 1'b1;
          s.sync_done   = 1'b1;
          s.new_day     = 1'b1;
        end
        if (s.receiver_on && item.fail_count >= FAILS_TO_RESET) begin
          stop            = 1'b1;
          s.receiver_on   = 1'b0;
          s.restart_delay = RESET_DELAY;
        end
        if (st.refresh_count >= UPDATE_TICKS) begin
          s.refresh_count = 8'd0;
          s.held_date     = load_date;
          s.held_time     = {item.hours, item.minutes};
          s.held_weekday  = item.weekday;
          if (load_date != st.held_date) s.new_day = 1'b1;
        end

        month   = s.held_date[8:5];
        day     = s.held_date[4:0];
        hours   = s.held_time[10:6];
        minutes = s.held_time[5:0];

        // arm the last-Sunday change whenever new_day is set
        if (s.new_day) begin
          s.new_day = 1'b0;
          if (cfg.auto_transition) begin
            s.pending_change = CHG_NONE;
            if (hours < 5'd2 && s.held_weekday == SUNDAY_CODE &&
                ({1'b0, day} + 6'd7) > MARCH_OCT_DAYS) begin
              if (month == MONTH_MARCH)        s.pending_change = CHG_SUMMER;
              else if (month == MONTH_OCTOBER) s.pending_change = CHG_WINTER;
            end
          end
        end

        if (cfg.auto_transition && s.pending_change != CHG_NONE) begin
          if (s.pending_change == CHG_SUMMER && hours == 5'd2) begin
            hours            = 5'd3;
            wcur             = 1'b1;
            s.pending_change = CHG_NONE;
          end else if (s.pending_change == CHG_WINTER && hours == 5'd3) begin
            hours            = 5'd2;
            wcur             = 1'b1;
            s.pending_change = CHG_NONE;
          end
          s.held_time = {hours, minutes};
        end

        cur = {6'd0, hours} * MINUTES_PER_HR + {5'd0, minutes};
        hi  = {1'b0, cfg.sync_start_minutes} + {1'b0, cfg.sync_length_minutes};

        // window opening clears the done flag
        if (cfg.sync_start_minutes != 11'd0) begin
          if (st.last_minute_of_day < cfg.sync_start_minutes &&
              cur >= cfg.sync_start_minutes)
            s.sync_done = 1'b0;
        end else begin
          if (st.last_minute_of_day == LAST_MINUTE && cur == 11'd0)
            s.sync_done = 1'b0;
        end
        s.last_minute_of_day = cur;

        if (hi < MINUTES_PER_DAY) begin
          can = (cur >= cfg.sync_start_minutes) && ({1'b0, cur} < hi);
        end else begin
          hi_wrap = hi - MINUTES_PER_DAY;
          can = (cur >= cfg.sync_start_minutes) || ({1'b0, cur} < hi_wrap);
        end

        if (!s.sync_done && can) begin
          if (!s.receiver_on && s.restart_delay == 8'd0) begin
            s.receiver_on = 1'b1;
            start         = 1'b1;
          end
        end else if (s.receiver_on) begin
          s.receiver_on = 1'b0;
          stop          = 1'b1;
        end else begin
          s.restart_delay = 8'd0;
        end
      end

      CMD_SET: begin
        s.new_day        = 1'b1;
        s.sync_done      = 1'b0;
        s.pending_change = CHG_NONE;
        s.held_date      = load_date;
        s.held_time      = {item.hours, item.minutes};
        s.held_weekday   = item.weekday;
        wcur             = 1'b1;
      end

      default: ;  // unused command: no change
    endcase

    st_next                = s;
    res.receiver_start     = start;
    res.receiver_stop      = stop;
    res.write_decoded      = wdec;
    res.write_current      = wcur;
    res.held_hours         = s.held_time[10:6];
    res.transition         = s.pending_change;
    res.synced_today       = s.sync_done;
  end

endmodule

// File: verif/csds_checker.sv
// ----------------------------------------------------------------------------
// csds_checker
// Watches the config, input and status channels of the clock sync supervisor,
// predicts each status beat from a local copy of the supervisor state and
// compares it field by field with what the block returns.
// ----------------------------------------------------------------------------
module csds_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [39:0] s_tdata,
  input  logic [1:0]  s_tuser,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [15:0] m_tdata,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [10:0] cfg_data,
  output int          mismatches,
  output int          outstanding,
  output int          checked
);
  timeunit 1ns;
  timeprecision 1ps;
  import csds_pkg::*;

  sup_state_t sup;
  cfg_t       regs;
  result_t    predicted_status[$];

  function automatic string show(input result_t r);
    return $sformatf("start=%0d stop=%0d wdec=%0d wcur=%0d hours=%0d trans=%0d synced=%0d",
                     r.receiver_start, r.receiver_stop, r.write_decoded, r.write_current,
                     r.held_hours, r.transition, r.synced_today);
  endfunction

  task automatic load_held(input item_t it);
    sup.held_date    = {it.year, it.month, it.day};
    sup.held_time    = {it.hours, it.minutes};
    sup.held_weekday = it.weekday;
  endtask

  // One supervisor step: updates the local state, returns the status beat.
  task automatic supervise(input item_t it, output result_t r);
    logic [15:0] old_date;
    logic [3:0]  mon;
    logic [4:0]  dy;
    logic [4:0]  hr;
    logic [5:0]  mn;
    int          cur;
    int          lo;
    int          hi;
    bit          can;
    r   = '0;
    can = 1'b0;
    case (it.cmd)
      CMD_TICK: begin
        sup.refresh_count = sup.refresh_count + 8'd1;
        if (sup.restart_delay != 8'd0) begin
          sup.restart_delay = sup.restart_delay - 8'd1;
          if (sup.restart_delay == 8'd0 && !sup.receiver_on) begin
            sup.receiver_on  = 1'b1;
            r.receiver_start = 1'b1;
          end
        end
      end
      CMD_PROCESS: begin
        if (it.frame_ok) begin
          r.receiver_stop = 1'b1;
          r.write_decoded = 1'b1;
          sup.receiver_on = 1'b0;
          sup.sync_done   = 1'b1;
          sup.new_day     = 1'b1;
        end
        if (sup.receiver_on && it.fail_count >= FAILS_TO_RESET) begin
          r.receiver_stop   = 1'b1;
          sup.receiver_on   = 1'b0;
          sup.restart_delay = RESET_DELAY;
        end
        if (sup.refresh_count >= UPDATE_TICKS) begin
          old_date          = sup.held_date;
          sup.refresh_count = 8'd0;
          load_held(it);
          if (sup.held_date != old_date) sup.new_day = 1'b1;
        end

        mon = sup.held_date[8:5];
        dy  = sup.held_date[4:0];
        hr  = sup.held_time[10:6];
        mn  = sup.held_time[5:0];

        // arm the change only on the last Sunday of the month, before 02:00
        if (sup.new_day) begin
          sup.new_day = 1'b0;
          if (regs.auto_transition) begin
            sup.pending_change = CHG_NONE;
            if (hr < 5'd2 && sup.held_weekday == SUNDAY_CODE &&
                int'(dy) + 7 > int'(MARCH_OCT_DAYS)) begin
              if (mon == MONTH_MARCH) sup.pending_change = CHG_SUMMER;
              else if (mon == MONTH_OCTOBER) sup.pending_change = CHG_WINTER;
            end
          end
        end

        if (regs.auto_transition && sup.pending_change != CHG_NONE) begin
          if (sup.pending_change == CHG_SUMMER && hr == 5'd2) begin
            hr                 = 5'd3;
            r.write_current    = 1'b1;
            sup.pending_change = CHG_NONE;
          end else if (sup.pending_change == CHG_WINTER && hr == 5'd3) begin
            hr                 = 5'd2;
            r.write_current    = 1'b1;
            sup.pending_change = CHG_NONE;
          end
          sup.held_time = {hr, mn};
        end

        cur = int'(hr) * 60 + int'(mn);
        lo  = int'(regs.sync_start_minutes);
        hi  = lo + int'(regs.sync_length_minutes);

        // window opening clears the done flag; a window at minute 0 opens at midnight
        if (lo != 0) begin
          if (int'(sup.last_minute_of_day) < lo && cur >= lo) sup.sync_done = 1'b0;
        end else if (sup.last_minute_of_day == LAST_MINUTE && cur == 0) begin
          sup.sync_done = 1'b0;
        end
        sup.last_minute_of_day = 11'(cur);

        if (hi < int'(MINUTES_PER_DAY)) begin
          can = (cur >= lo && cur < hi);
        end else begin
          hi  = hi - int'(MINUTES_PER_DAY);
          can = (cur >= lo || cur < hi);
        end

        if (!sup.sync_done && can) begin
          if (!sup.receiver_on && sup.restart_delay == 8'd0) begin
            sup.receiver_on  = 1'b1;
            r.receiver_start = 1'b1;
          end
        end else if (sup.receiver_on) begin
          sup.receiver_on = 1'b0;
          r.receiver_stop = 1'b1;
        end else begin
          sup.restart_delay = 8'd0;
        end
      end
      CMD_SET: begin
        sup.new_day        = 1'b1;
        sup.sync_done      = 1'b0;
        sup.pending_change = CHG_NONE;
        load_held(it);
        r.write_current    = 1'b1;
      end
      default: ;
    endcase
    r.held_hours   = sup.held_time[10:6];
    r.transition   = sup.pending_change;
    r.synced_today = sup.sync_done;
  endtask

  task automatic compare_status(input result_t want, input result_t got,
                                input logic [3:0] pad);
    string bad;
    bad = "";
    if (got.receiver_start !== want.receiver_start) bad = {bad, " receiver_start"};
    if (got.receiver_stop  !== want.receiver_stop)  bad = {bad, " receiver_stop"};
    if (got.write_decoded  !== want.write_decoded)  bad = {bad, " write_decoded"};
    if (got.write_current  !== want.write_current)  bad = {bad, " write_current"};
    if (got.held_hours     !== want.held_hours)     bad = {bad, " held_hours"};
    if (got.transition     !== want.transition)     bad = {bad, " transition"};
    if (got.synced_today   !== want.synced_today)   bad = {bad, " synced_today"};
    if (pad !== 4'd0)                               bad = {bad, " padding"};
    if (bad != "") begin
      if (mismatches < 10)
        $display("status beat %0d mismatch:%s\n  want %s\n  got  %s pad=%h",
                 checked, bad, show(want), show(got), pad);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    item_t   it;
    result_t got;
    result_t want;
    if (rst) begin
      sup                   = '0;
      sup.refresh_count     = UPDATE_TICKS;
      sup.new_day           = 1'b1;
      regs                  = '0;
      regs.sync_length_minutes = 11'd60;
      predicted_status.delete();
      mismatches            = 0;
      outstanding           = 0;
      checked               = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_AUTO_TRANSITION: regs.auto_transition     = cfg_data[0];
          REG_SYNC_START:      regs.sync_start_minutes  = cfg_data;
          REG_SYNC_LENGTH:     regs.sync_length_minutes = cfg_data;
          default: ;
        endcase
      end
      if (m_tvalid && m_tready) begin
        got.receiver_start = m_tdata[0];
        got.receiver_stop  = m_tdata[1];
        got.write_decoded  = m_tdata[2];
        got.write_current  = m_tdata[3];
        got.held_hours     = m_tdata[8:4];
        got.transition     = m_tdata[10:9];
        got.synced_today   = m_tdata[11];
        if (predicted_status.size() == 0) begin
          if (mismatches < 10)
            $display("status beat %0d arrived with nothing predicted: %s", checked, show(got));
          mismatches++;
        end else begin
          want = predicted_status.pop_front();
          compare_status(want, got, m_tdata[15:12]);
        end
        checked++;
      end
      if (s_tvalid && s_tready) begin
        it.cmd        = s_tuser;
        it.year       = s_tdata[6:0];
        it.month      = s_tdata[10:7];
        it.day        = s_tdata[15:11];
        it.hours      = s_tdata[20:16];
        it.minutes    = s_tdata[26:21];
        it.weekday    = s_tdata[29:27];
        it.frame_ok   = s_tdata[30];
        it.fail_count = s_tdata[38:31];
        supervise(it, want);
        predicted_status.push_back(want);
      end
      outstanding = predicted_status.size();
    end
  end

endmodule

// File: verif/tb.sv
// ----------------------------------------------------------------------------
// tb
// Stimulus for the clock sync supervisor: directed corner items, a refresh
// counter wrap, then phases of simulated clock runs around the daylight-saving
// Sundays, the sync window and receiver faults, mixed with noise, under
// random stalls on both streams. Checking lives in csds_checker.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import csds_pkg::*;

  localparam logic [1:0] CMD_UNUSED   = 2'd3;
  localparam logic [1:0] REG_NONE     = 2'd3;
  localparam int         RANDOM_ITEMS = 1100;
  localparam int         DRAIN_CYCLES = 8;

  typedef enum int {SC_DST, SC_WINDOW, SC_FAULT, SC_NOISE} scenario_e;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [39:0] s_tdata;
  logic [1:0]  s_tuser;
  logic        m_tvalid;
  logic        m_tready;
  logic [15:0] m_tdata;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [10:0] cfg_data;

  int mismatches;
  int outstanding;
  int checked;

  int items_sent = 0;
  int reg_writes = 0;
  int phases     = 0;
  int sc_count[4] = '{0, 0, 0, 0};
  bit s_steady   = 1'b0;
  bit m_steady   = 1'b0;
  int win_start  = 0;

  // simulated wall clock
  int c_yr, c_mo, c_dy, c_hr, c_mn, c_wd;

  clock_sync_dst_supervisor_core u_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  csds_checker u_check (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tuser     (s_tuser),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .mismatches  (mismatches),
    .outstanding (outstanding),
    .checked     (checked)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #2ms;
    $display("timeout with %0d status beats outstanding", outstanding);
    $display("== FAIL ==");
    $finish;
  end

  function automatic item_t mk(input logic [1:0] cmd, input int yr, input int mo,
                               input int dy, input int hr, input int mn, input int wd,
                               input int fok, input int fc);
    item_t it;
    it.cmd        = cmd;
    it.year       = 7'(yr);
    it.month      = 4'(mo);
    it.day        = 5'(dy);
    it.hours      = 5'(hr);
    it.minutes    = 6'(mn);
    it.weekday    = 3'(wd);
    it.frame_ok   = 1'(fok);
    it.fail_count = 8'(fc);
    return it;
  endfunction

  function automatic item_t rand_item();
    return mk(2'($urandom_range(0, 3)), $urandom_range(0, 127), $urandom_range(0, 15),
              $urandom_range(0, 31), $urandom_range(0, 31), $urandom_range(0, 63),
              $urandom_range(0, 7), $urandom_range(0, 1), $urandom_range(0, 255));
  endfunction

  function automatic logic [39:0] beat_data(input item_t it);
    return {1'b0, it.fail_count, it.frame_ok, it.weekday, it.minutes, it.hours,
            it.day, it.month, it.year};
  endfunction

  // mostly short idles, now and then a long one
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic send_item(input item_t it);
    int gap;
    gap = (s_steady || $urandom_range(0, 99) >= 30) ? 0 : idle_len();
    if (gap > 0) begin
      @(negedge clk);
      s_tvalid <= 1'b0;
      s_tdata  <= beat_data(rand_item());
      s_tuser  <= 2'($urandom_range(0, 3));
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tdata  <= beat_data(it);
    s_tuser  <= it.cmd;
    do @(posedge clk); while (!s_tready);
    items_sent++;
  endtask

  // registers change only with the block drained
  task automatic write_cfg(input logic [1:0] idx, input logic [10:0] data);
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    reg_writes++;
  endtask

  task automatic tick_burst(input int long_pct);
    int     r;
    int     n;
    item_t  it;
    r = $urandom_range(0, 99);
    if (r < long_pct) n = $urandom_range(95, 110);
    else if (r < long_pct + 45) n = $urandom_range(9, 12);
    else n = $urandom_range(0, 2);
    repeat (n) begin
      it     = rand_item();
      it.cmd = CMD_TICK;
      send_item(it);
    end
  endtask

  task automatic advance(input int n);
    int mdays;
    c_mn += n;
    while (c_mn >= 60) begin
      c_mn -= 60;
      c_hr++;
      if (c_hr == 24) begin
        c_hr = 0;
        c_wd = c_wd % 7 + 1;
        c_dy++;
        mdays = (c_mo == 2) ? 28 :
                (c_mo == 4 || c_mo == 6 || c_mo == 9 || c_mo == 11) ? 30 : 31;
        if (c_dy > mdays) begin
          c_dy = 1;
          c_mo++;
          if (c_mo > 12) begin
            c_mo = 1;
            c_yr = (c_yr + 1) % 100;
          end
        end
      end
    end
  endtask

  task automatic pick_date();
    c_yr = $urandom_range(0, 99);
    c_mo = $urandom_range(1, 12);
    c_dy = $urandom_range(1, 28);
    c_wd = $urandom_range(1, 7);
  endtask

  // set the clock, then ticks and process steps with the RTC reading advancing
  task automatic run_clock(input int steps, input int step_max, input int frame_pct,
                           input int fail_pct, input int long_pct);
    item_t it;
    send_item(mk(CMD_SET, c_yr, c_mo, c_dy, c_hr, c_mn, c_wd,
                 $urandom_range(0, 1), $urandom_range(0, 255)));
    repeat (steps) begin
      tick_burst(long_pct);
      it = mk(CMD_PROCESS, c_yr, c_mo, c_dy, c_hr, c_mn, c_wd,
              $urandom_range(0, 99) < frame_pct,
              ($urandom_range(0, 99) < fail_pct) ? $urandom_range(5, 255)
                                                  : $urandom_range(0, 4));
      if ($urandom_range(0, 99) < 4) begin
        it     = rand_item();
        it.cmd = CMD_PROCESS;
      end
      send_item(it);
      advance($urandom_range(0, step_max));
    end
  endtask

  initial begin
    int        stall_left;
    stall_left = 0;
    m_tready   = 1'b0;
    forever begin
      @(negedge clk);
      if (m_steady) begin
        m_tready <= 1'b1;
      end else if (stall_left > 0) begin
        m_tready <= 1'b0;
        stall_left--;
      end else if ($urandom_range(0, 99) < 25) begin
        m_tready <= 1'b0;
        stall_left = idle_len() - 1;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  initial begin
    item_t       it;
    int          base;
    int          m;
    scenario_e   sc;
    logic [10:0] v;
    rst       = 1'b1;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    s_tuser   = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed corners, reset register values first
    send_item(mk(CMD_TICK, 127, 15, 31, 31, 63, 7, 1, 255));     // ignored fields all ones
    send_item(mk(CMD_PROCESS, 99, 12, 31, 23, 59, 7, 0, 0));     // first refresh loads
    send_item(mk(CMD_PROCESS, 0, 1, 1, 0, 0, 1, 1, 255));        // frame with receiver off
    send_item(mk(CMD_UNUSED, 127, 15, 31, 31, 63, 7, 1, 255));
    send_item(mk(CMD_UNUSED, 0, 0, 0, 0, 0, 0, 0, 0));
    send_item(mk(CMD_SET, 0, 1, 1, 0, 0, 0, 1, 255));            // radio fields ignored
    send_item(mk(CMD_PROCESS, 0, 0, 0, 0, 0, 0, 0, 4));
    send_item(mk(CMD_SET, 127, 15, 31, 31, 63, 7, 0, 0));        // out-of-range time
    send_item(mk(CMD_PROCESS, 127, 15, 31, 31, 63, 7, 0, 255));  // minute of day 1923
    send_item(mk(CMD_SET, 24, 3, 31, 1, 59, 7, 0, 0));           // last Sunday, auto off
    send_item(mk(CMD_PROCESS, 24, 3, 31, 1, 59, 7, 0, 0));
    write_cfg(REG_AUTO_TRANSITION, 11'h7ff);
    write_cfg(REG_SYNC_START, 11'd1439);
    write_cfg(REG_SYNC_LENGTH, 11'd0);
    send_item(mk(CMD_SET, 24, 10, 27, 1, 30, 7, 0, 0));          // arms winter change
    send_item(mk(CMD_PROCESS, 24, 10, 27, 3, 0, 7, 0, 0));
    send_item(mk(CMD_TICK, 0, 0, 0, 0, 0, 0, 0, 0));
    send_item(mk(CMD_PROCESS, 24, 10, 27, 23, 59, 7, 1, 0));
    write_cfg(REG_SYNC_START, 11'd0);
    write_cfg(REG_SYNC_LENGTH, 11'd2047);
    send_item(mk(CMD_PROCESS, 24, 10, 27, 0, 0, 7, 0, 0));
    send_item(mk(CMD_PROCESS, 24, 10, 27, 0, 1, 7, 0, 200));

    // refresh counter runs past 255 without a process step
    send_item(mk(CMD_PROCESS, 1, 2, 3, 4, 5, 6, 0, 0));
    repeat (260) send_item(mk(CMD_TICK, 0, 0, 0, 0, 0, 0, 0, 0));
    send_item(mk(CMD_PROCESS, 1, 2, 4, 5, 6, 7, 0, 0));

    base = items_sent;
    while (items_sent - base < RANDOM_ITEMS) begin
      sc       = scenario_e'($urandom_range(0, 3));
      s_steady = ($urandom_range(0, 3) == 0);
      m_steady = ($urandom_range(0, 3) == 0);

      v = 11'($urandom_range(0, 2047));
      if (sc == SC_DST) v[0] = ($urandom_range(0, 9) != 0);
      write_cfg(REG_AUTO_TRANSITION, v);
      case (phases % 5)
        0:       v = 11'd0;
        1:       v = 11'd1439;
        2:       v = 11'd2047;
        3:       v = 11'($urandom_range(0, 1439));
        default: v = 11'($urandom_range(0, 2047));
      endcase
      win_start = int'(v);
      write_cfg(REG_SYNC_START, v);
      case ((phases + phases / 5) % 6)
        0:       v = 11'd1440;
        1:       v = 11'd0;
        2:       v = 11'd2047;
        3:       v = 11'd60;
        4:       v = 11'($urandom_range(0, 1440));
        default: v = 11'($urandom_range(0, 2047));
      endcase
      if (sc == SC_FAULT && $urandom_range(0, 1) == 1) v = 11'd1440;
      write_cfg(REG_SYNC_LENGTH, v);
      if ($urandom_range(0, 5) == 0) write_cfg(REG_NONE, 11'($urandom_range(0, 2047)));

      pick_date();
      case (sc)
        SC_DST: begin
          c_mo = ($urandom_range(0, 1) == 1) ? 3 : 10;
          c_dy = ($urandom_range(0, 4) != 0) ? $urandom_range(25, 31) : $urandom_range(18, 31);
          c_wd = ($urandom_range(0, 4) != 0) ? 7 : $urandom_range(1, 7);
          c_hr = 1;
          c_mn = $urandom_range(30, 59);
          run_clock(25, 6, 3, 5, 0);
        end
        SC_WINDOW: begin
          // start a little before the window opens, wrapping into the previous day
          m    = (win_start % 1440 + 1440 - $urandom_range(0, 40)) % 1440;
          c_hr = m / 60;
          c_mn = m % 60;
          run_clock(25, 20, 15, 10, 2);
        end
        SC_FAULT: begin
          c_hr = $urandom_range(0, 23);
          c_mn = $urandom_range(0, 59);
          run_clock(20, 2, 5, 40, 15);
        end
        default: begin
          repeat (40) begin
            if ($urandom_range(0, 1) == 1) it = rand_item();
            else it = mk(2'($urandom_range(0, 3)), $urandom_range(0, 99), $urandom_range(1, 12),
                         $urandom_range(1, 31), $urandom_range(0, 23), $urandom_range(0, 59),
                         $urandom_range(0, 7), $urandom_range(0, 1), $urandom_range(0, 255));
            send_item(it);
          end
        end
      endcase
      sc_count[sc]++;
      phases++;
    end

    @(negedge clk);
    s_tvalid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("sent %0d input beats over %0d phases with %0d register writes",
             items_sent, phases, reg_writes);
    $display("%0d status beats checked, %0d bad; phases: dst %0d, sync window %0d,",
             checked, mismatches, sc_count[SC_DST], sc_count[SC_WINDOW]);
    $display("  receiver faults %0d, noise %0d", sc_count[SC_FAULT], sc_count[SC_NOISE]);
    if (mismatches == 0 && outstanding == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
